/* src/tcw_pkg.sv */
// Shared constants, types and command/status structs for the text console writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 24;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h02;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ATTR_W-1:0] t_attr;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef struct packed {
        logic sweep;
        logic accept;
        logic load_read;
        logic load_sweep;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
        logic is_read;
        logic scroll;
    } t_dp_stat;

endpackage

/* src/tcw_if.sv */
// Request, response and configuration channel interfaces of the text console writer.
interface tcw_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    tcw_pkg::t_char     char_code;
    tcw_pkg::t_idx      cell_index;

    modport source (output valid, output func, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input func, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_out_if;
    logic               valid;
    logic               ready;
    tcw_pkg::t_cell     cell_data;
    tcw_pkg::t_col      cursor_col;
    tcw_pkg::t_row      cursor_row;

    modport source (output valid, output cell_data, output cursor_col, output cursor_row,
                    input ready);
    modport sink (input valid, input cell_data, input cursor_col, input cursor_row,
                  output ready);
endinterface

interface tcw_cfg_if;
    logic               valid;
    logic               ready;
    tcw_pkg::t_attr     text_attribute;

    modport source (output valid, output text_attribute, input ready);
    modport sink (input valid, input text_attribute, output ready);
endinterface

/* src/tcw_ctrl.sv */
// Controller state machine: reset clearing pass, request intake, read wait and scroll clear.
module tcw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  tcw_pkg::t_dp_stat  i_stat,
    output logic               o_req_ready,
    output tcw_pkg::t_dp_cmd   o_cmd
);
    import tcw_pkg::*;

    localparam logic [1:0] S_INIT   = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_SCROLL = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    always_comb begin
        o_req_ready = (r_state == S_IDLE) && i_stat.out_free;
        accept      = o_req_ready && i_req_valid;
        o_cmd       = '0;
        n_state     = r_state;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.is_read) begin
                        n_state = S_READ;
                    end else if (i_stat.scroll) begin
                        n_state = S_SCROLL;
                    end
                end
            end
            S_READ: begin
                o_cmd.load_read = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCROLL: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.load_sweep = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/tcw_dp.sv */
// Datapath: screen memory with rotating top row, cursor, attribute, sweep counter and output register.
module tcw_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_dp_cmd   i_cmd,
    output tcw_pkg::t_dp_stat  o_stat,
    input  logic               i_func,
    input  tcw_pkg::t_char     i_char_code,
    input  tcw_pkg::t_idx      i_cell_index,
    input  logic               i_cfg_valid,
    input  tcw_pkg::t_attr     i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output tcw_pkg::t_cell     o_cell_data,
    output tcw_pkg::t_col      o_cursor_col,
    output tcw_pkg::t_row      o_cursor_row
);
    import tcw_pkg::*;

    t_cell r_mem [CELLS];
    t_cell r_rd_data;
    logic  r_rd_oor;
    t_col  r_col;
    t_row  r_row;
    t_addr r_base;
    t_addr r_sweep_addr;
    t_addr r_sweep_last;
    t_attr r_attr;
    logic  r_out_valid;
    t_cell r_out_cell;
    t_col  r_out_col;
    t_row  r_out_row;

    t_col  n_col;
    t_row  n_row;
    t_col  col_inc;
    t_row  row_inc;
    logic  is_put;
    logic  wr_char;
    logic  scroll;
    t_addr lin_addr;
    t_addr wr_addr;
    t_addr rd_addr;
    logic  rd_oor;
    t_addr base_adv;
    t_addr base_next;
    logic  mem_we;
    t_addr mem_wa;
    t_cell mem_wd;
    logic  load_put;

    // Maps a logical cell index onto the memory, whose top screen row starts at base.
    function automatic t_addr to_phys(t_addr lin, t_addr base);
        logic [ADDR_W:0] sum;
        sum = {1'b0, lin} + {1'b0, base};
        if (sum >= (ADDR_W+1)'(CELLS)) begin
            sum = sum - (ADDR_W+1)'(CELLS);
        end
        return sum[ADDR_W-1:0];
    endfunction

    always_comb begin
        is_put  = (i_func == FUNC_PUT);
        col_inc = r_col + COL_W'(1);
        row_inc = r_row + ROW_W'(1);
        n_col   = r_col;
        n_row   = r_row;
        wr_char = 1'b0;
        case (i_char_code)
            CH_NEWLINE: begin
                n_row = row_inc;
                n_col = '0;
            end
            CH_RETURN: begin
                n_row = row_inc;
            end
            CH_BACKSPACE: begin
                if (r_col != '0) begin
                    n_col = r_col - COL_W'(1);
                end
            end
            default: begin
                wr_char = 1'b1;
                if (col_inc == COL_W'(COLUMNS)) begin
                    n_col = '0;
                    n_row = row_inc;
                end else begin
                    n_col = col_inc;
                end
            end
        endcase
        scroll = is_put && (n_row == ROW_W'(ROWS));
        if (scroll) begin
            n_row = ROW_W'(ROWS - 1);
        end
    end

    always_comb begin
        lin_addr  = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
        wr_addr   = to_phys(lin_addr, r_base);
        rd_addr   = to_phys(ADDR_W'(i_cell_index), r_base);
        rd_oor    = (i_cell_index >= IDX_W'(CELLS));
        base_adv  = r_base + ADDR_W'(COLUMNS);
        base_next = (base_adv == ADDR_W'(CELLS)) ? '0 : base_adv;
        mem_we    = i_cmd.sweep || (i_cmd.accept && is_put && wr_char);
        mem_wa    = i_cmd.sweep ? r_sweep_addr : wr_addr;
        mem_wd    = i_cmd.sweep ? '0 : {r_attr, i_char_code};
        load_put  = i_cmd.accept && is_put && !scroll;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_oor <= rd_oor;
        end
        if (load_put) begin
            r_out_cell <= '0;
            r_out_col  <= n_col;
            r_out_row  <= n_row;
        end else if (i_cmd.load_read) begin
            r_out_cell <= r_rd_oor ? '0 : r_rd_data;
            r_out_col  <= r_col;
            r_out_row  <= r_row;
        end else if (i_cmd.load_sweep) begin
            r_out_cell <= '0;
            r_out_col  <= r_col;
            r_out_row  <= r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_base       <= '0;
            r_sweep_addr <= '0;
            r_sweep_last <= ADDR_W'(CELLS - 1);
            r_attr       <= ATTR_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.accept && is_put) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cmd.accept && scroll) begin
                r_base       <= base_next;
                r_sweep_addr <= r_base;
                r_sweep_last <= r_base + ADDR_W'(COLUMNS - 1);
            end else if (i_cmd.sweep) begin
                r_sweep_addr <= r_sweep_addr + ADDR_W'(1);
            end
            if (load_put || i_cmd.load_read || i_cmd.load_sweep) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.sweep_last = (r_sweep_addr == r_sweep_last);
        o_stat.out_free   = !r_out_valid || i_out_ready;
        o_stat.is_read    = (i_func == FUNC_READ);
        o_stat.scroll     = scroll;
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_data  = r_out_cell;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;

endmodule

/* src/text_console_writer.sv */
// Top level of the text console writer: 24 x 80 cell screen with cursor, put and read requests.
// A put request without scroll has its response registered in the cycle after acceptance.
// A put that scrolls first clears each cell of the new bottom row before its response is registered.
// A read request responds through the registered memory port: the cell is read into a register, then loaded.
// Puts without scroll are accepted every cycle while responses drain; a read blocks requests until loaded.
// After reset a clearing pass zeroes every cell of the screen with request ready held low.
module text_console_writer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcw_in_if.sink     i_req,
    tcw_out_if.source  o_rsp,
    tcw_cfg_if.sink    i_cfg
);
    import tcw_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign i_cfg.ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    tcw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_req.func),
        .i_char_code  (i_req.char_code),
        .i_cell_index (i_req.cell_index),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.text_attribute),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_cell_data  (o_rsp.cell_data),
        .o_cursor_col (o_rsp.cursor_col),
        .o_cursor_row (o_rsp.cursor_row)
    );

endmodule

/* src/tcw_checker.sv */
// Port-level assertion checker for the text console writer and its bind.
module tcw_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_in_func,
    input tcw_pkg::t_idx  i_in_idx,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input tcw_pkg::t_cell i_out_cell,
    input tcw_pkg::t_col  i_out_col,
    input tcw_pkg::t_row  i_out_row
);
    import tcw_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && !i_in_ready))
        else $error("response or ready active right after reset");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_col < COL_W'(COLUMNS) && i_out_row < ROW_W'(ROWS)))
        else $error("cursor outside the screen");

    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> (!i_out_valid || i_out_ready))
        else $error("request taken while the response register is blocked");

    a_oor_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_func == FUNC_READ && i_in_idx >= IDX_W'(CELLS))
        |=> ##1 (i_out_valid && i_out_cell == '0))
        else $error("read beyond the screen did not return zero");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_cell)
        && $stable(i_out_col) && $stable(i_out_row)))
        else $error("stalled response changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_func   (i_req.func),
    .i_in_idx    (i_req.cell_index),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_cell  (o_rsp.cell_data),
    .i_out_col   (o_rsp.cursor_col),
    .i_out_row   (o_rsp.cursor_row)
);

/* tb/tcw_screen_checker.sv */
`timescale 1ns / 100ps
// Checker that tracks the console screen and cursor and compares every response of the writer.
module tcw_screen_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic              i_req_func,
    input  tcw_pkg::t_char    i_req_char,
    input  tcw_pkg::t_idx     i_req_index,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  tcw_pkg::t_cell    i_rsp_cell,
    input  tcw_pkg::t_col     i_rsp_col,
    input  tcw_pkg::t_row     i_rsp_row,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  tcw_pkg::t_attr    i_cfg_attr,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        tcw_pkg::t_cell cell_word;
        tcw_pkg::t_col  col;
        tcw_pkg::t_row  row;
    } t_screen_reply;

    tcw_pkg::t_cell shadow_screen [tcw_pkg::CELLS];
    int             shadow_col;
    int             shadow_row;
    tcw_pkg::t_attr shadow_attr;
    t_screen_reply  awaited_replies [$];
    int             mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic t_screen_reply screen_step(logic func, tcw_pkg::t_char ch,
                                                  tcw_pkg::t_idx idx);
        t_screen_reply reply;
        int            k;
        reply.cell_word = '0;
        if (func == tcw_pkg::FUNC_PUT) begin
            if (ch == tcw_pkg::CH_NEWLINE) begin
                shadow_row++;
                shadow_col = 0;
            end else if (ch == tcw_pkg::CH_RETURN) begin
                shadow_row++;
            end else if (ch == tcw_pkg::CH_BACKSPACE) begin
                if (shadow_col > 0)
                    shadow_col--;
            end else begin
                shadow_screen[shadow_row * tcw_pkg::COLUMNS + shadow_col] = {shadow_attr, ch};
                shadow_col++;
                if (shadow_col >= tcw_pkg::COLUMNS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
            end
            if (shadow_row >= tcw_pkg::ROWS) begin
                for (k = 0; k < tcw_pkg::CELLS - tcw_pkg::COLUMNS; k++)
                    shadow_screen[k] = shadow_screen[k + tcw_pkg::COLUMNS];
                for (k = tcw_pkg::CELLS - tcw_pkg::COLUMNS; k < tcw_pkg::CELLS; k++)
                    shadow_screen[k] = '0;
                shadow_row = tcw_pkg::ROWS - 1;
            end
        end else if (idx < tcw_pkg::CELLS) begin
            reply.cell_word = shadow_screen[idx];
        end
        reply.col = tcw_pkg::t_col'(shadow_col);
        reply.row = tcw_pkg::t_row'(shadow_row);
        return reply;
    endfunction

    always @(posedge i_clk) begin : watch
        t_screen_reply want;
        t_screen_reply got;
        int            k;
        if (!i_rst_n) begin
            for (k = 0; k < tcw_pkg::CELLS; k++)
                shadow_screen[k] = '0;
            shadow_col = 0;
            shadow_row = 0;
            shadow_attr = tcw_pkg::ATTR_RESET;
            awaited_replies.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = {i_rsp_cell, i_rsp_col, i_rsp_row};
                if (awaited_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response with no request waiting: cell %h col %0d row %0d",
                                 $realtime, got.cell_word, got.col, got.row);
                end else begin
                    want = awaited_replies.pop_front();
                    if (want.cell_word !== got.cell_word || want.col !== got.col
                            || want.row !== got.row) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: response mismatch: cell %h/%h col %0d/%0d row %0d/%0d %s",
                                     $realtime, want.cell_word, got.cell_word, want.col, got.col,
                                     want.row, got.row, "(expected/actual)");
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                shadow_attr = i_cfg_attr;
            if (i_req_valid && i_req_ready)
                awaited_replies.push_back(screen_step(i_req_func, i_req_char, i_req_index));
        end
        o_pending <= awaited_replies.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Top of the text console writer testbench: clock, reset, request traffic and the verdict.
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 190;

    logic clk;
    logic rst_n;
    logic no_idle = 1'b0;
    int   requests_sent = 0;
    int   replies_taken = 0;
    int   fail_count;
    int   leftover;

    tcw_in_if  req_ch ();
    tcw_out_if rsp_ch ();
    tcw_cfg_if cfg_ch ();

    text_console_writer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    tcw_screen_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req_func   (req_ch.func),
        .i_req_char   (req_ch.char_code),
        .i_req_index  (req_ch.cell_index),
        .i_rsp_valid  (rsp_ch.valid),
        .i_rsp_ready  (rsp_ch.ready),
        .i_rsp_cell   (rsp_ch.cell_data),
        .i_rsp_col    (rsp_ch.cursor_col),
        .i_rsp_row    (rsp_ch.cursor_row),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_attr   (cfg_ch.text_attribute),
        .o_fail_count (fail_count),
        .o_pending    (leftover)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic send_request(logic func, tcw_pkg::t_char ch, tcw_pkg::t_idx idx);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.char_code  <= ch;
        req_ch.cell_index <= idx;
        do @(posedge clk); while (!req_ch.ready);
        requests_sent++;
    endtask

    task automatic put_char(tcw_pkg::t_char ch);
        send_request(tcw_pkg::FUNC_PUT, ch, tcw_pkg::t_idx'($urandom));
    endtask

    task automatic read_cell(tcw_pkg::t_idx idx);
        send_request(tcw_pkg::FUNC_READ, tcw_pkg::t_char'($urandom), idx);
    endtask

    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        while (requests_sent != replies_taken)
            @(posedge clk);
    endtask

    task automatic write_attribute(tcw_pkg::t_attr value);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.text_attribute <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(int count, int newline_pct);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < newline_pct)
                put_char(tcw_pkg::CH_NEWLINE);
            else if (pick < newline_pct + 4)
                put_char(tcw_pkg::CH_RETURN);
            else if (pick < newline_pct + 10)
                put_char(tcw_pkg::CH_BACKSPACE);
            else if (pick < newline_pct + 26)
                read_cell(tcw_pkg::t_idx'($urandom_range(0, tcw_pkg::CELLS - 1)));
            else if (pick < newline_pct + 30)
                read_cell(tcw_pkg::t_idx'($urandom_range(tcw_pkg::CELLS, 2 ** tcw_pkg::IDX_W - 1)));
            else
                put_char(tcw_pkg::t_char'($urandom));
        end
    endtask

    initial begin
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.func           <= tcw_pkg::FUNC_PUT;
        req_ch.char_code      <= '0;
        req_ch.cell_index     <= '0;
        rsp_ch.ready          <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.text_attribute <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin : take_replies
        int stall;
        @(posedge clk iff rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            replies_taken++;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        tcw_pkg::t_attr attr_plan [6];
        attr_plan = '{8'hFF, 8'h00, tcw_pkg::t_attr'($urandom), 8'hA5, 8'h5A,
                      tcw_pkg::t_attr'($urandom)};
        @(posedge clk iff rst_n);

        // The screen is clear after reset, including both ends and past the end.
        read_cell('0);
        read_cell(tcw_pkg::t_idx'(tcw_pkg::CELLS - 1));
        read_cell(tcw_pkg::t_idx'(tcw_pkg::CELLS));
        read_cell('1);
        put_char(8'h48);
        put_char(8'h00);
        put_char(8'hFF);
        read_cell(11'd0);
        read_cell(11'd1);
        read_cell(11'd2);
        put_char(tcw_pkg::CH_BACKSPACE);
        put_char(tcw_pkg::CH_NEWLINE);
        put_char(tcw_pkg::CH_BACKSPACE);
        put_char(tcw_pkg::CH_RETURN);
        put_char(8'h78);
        put_char(tcw_pkg::CH_RETURN);
        read_cell(tcw_pkg::t_idx'(2 * tcw_pkg::COLUMNS));
        read_cell(11'd2);
        read_cell(11'h7F0);

        run_random(PHASE_ITEMS, 10);
        for (int phase = 0; phase < 6; phase++) begin
            drain_replies();
            write_attribute(attr_plan[phase]);
            no_idle = (phase % 3 == 1);
            run_random(PHASE_ITEMS, (phase % 2 == 0) ? 1 : 8);
        end
        drain_replies();
        no_idle = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && leftover == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/tcw_pkg.sv
src/tcw_if.sv
src/tcw_ctrl.sv
src/tcw_dp.sv
src/text_console_writer.sv
src/tcw_checker.sv
tb/tcw_screen_checker.sv
tb/tb_top.sv
